### design/cfp_pkg.sv
package cfp_pkg;

  // Width of the line number field carried on the result channel.
  localparam int unsigned LINE_OUT_W = 32;
  // Default width of the internal line counter.
  localparam int unsigned LINE_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic {
    ERR_BAD_QUOTE = 1'b0,
    ERR_UNCLOSED  = 1'b1
  } err_code_e;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_EOS  = 1'b1
  } op_e;

endpackage

### design/cfp_if.sv
// Input channel: one stream byte or an end-of-stream mark per word.
interface cfp_in_if;
  import cfp_pkg::*;

  logic       valid;
  logic       ready;
  op_e        op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// Result channel: one parse event per word.
interface cfp_out_if;
  import cfp_pkg::*;

  logic                  valid;
  logic                  ready;
  kind_e                 kind;
  logic [7:0]            content_byte;
  err_code_e             err_code;
  logic [LINE_OUT_W-1:0] line_number;

  modport source (output valid, output kind, output content_byte, output err_code,
                  output line_number, input ready);
  modport sink   (input valid, input kind, input content_byte, input err_code,
                  input line_number, output ready);
endinterface

### design/csv_field_parser.sv
// csv_field_parser - streaming CSV field splitter.
//
// in_i  : valid/ready channel of words {op, data_byte}. op = data carries one
//         stream byte, op = end-of-stream closes the stream (data_byte unused).
// out_o : valid/ready channel of parse events {kind, content_byte,
//         err_code, line_number}. A data byte gives at most one event:
//         a content byte, a field end, a field-and-record end or an error.
//         Opening/closing quotes and the LF after a record-ending CR give none.
//
// A word is captured in the input register and parsed from there; its event is
// loaded into the output register when the word advances out of the input
// register, which then raises out_o.valid.
// Throughput: one word per cycle while out_o takes events; the parse state
// update is a loop from the state registers through the byte decode and back.
//
// Stalls: when out_o.ready is low with an event held, the input register keeps
// its word and in_i.ready drops, even for a word that would give no event.
// Reset (rst_ni low, asynchronous): both registers empty, parser in the start
// state, line counter at one, error and flags clear. An end-of-stream word
// returns the parser to the same state after giving its final event.
module csv_field_parser #(
  parameter int unsigned LINE_WIDTH = cfp_pkg::LINE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfp_in_if.sink     in_i,
  cfp_out_if.source  out_o
);
  import cfp_pkg::*;

  // Quote machine state codes.
  localparam logic [1:0] ST_START  = 2'd0;
  localparam logic [1:0] ST_PLAIN  = 2'd1;
  localparam logic [1:0] ST_QUOTED = 2'd2;
  localparam logic [1:0] ST_CLOSED = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [LINE_WIDTH-1:0] LINE_ONE = LINE_WIDTH'(1);

  // Input register.
  logic       in_vld_q;
  op_e        op_q;
  logic [7:0] byte_q;

  // Parser state.
  logic [1:0]            st_q, st_d;
  logic [LINE_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic                  has_data_q, has_data_d;
  logic                  skip_lf_q, skip_lf_d;
  logic                  err_q, err_d;

  // Output register.
  logic                  out_vld_q;
  kind_e                 kind_q, kind_d;
  logic [7:0]            cbyte_q, cbyte_d;
  err_code_e             ecode_q, ecode_d;
  logic [LINE_OUT_W-1:0] lnum_q, lnum_d;
  logic                  emit;

  // Counter value extended so the low output bits can always be selected.
  logic [LINE_WIDTH+LINE_OUT_W-1:0] lnum_ext;

  logic advance;

  // Parse the held word when the output register is free or being emptied.
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  assign cnt_inc = (cnt_q != '1) ? cnt_q + LINE_ONE : cnt_q;

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    has_data_d = has_data_q;
    skip_lf_d  = skip_lf_q;
    err_d      = err_q;
    emit       = 1'b0;
    kind_d     = KIND_BYTE;
    cbyte_d    = 8'h00;
    ecode_d    = ERR_BAD_QUOTE;

    if (op_q == OP_EOS) begin
      if (!err_q) begin
        if (st_q == ST_QUOTED) begin
          emit    = 1'b1;
          kind_d  = KIND_ERROR;
          ecode_d = ERR_UNCLOSED;
        end else if (has_data_q) begin
          emit   = 1'b1;
          kind_d = KIND_RECORD;
        end
      end
    end else if (!err_q) begin
      skip_lf_d = 1'b0;
      if (!(skip_lf_q && byte_q == CH_LF)) begin
        has_data_d = 1'b1;
        if (byte_q == CH_LF) begin
          cnt_d = cnt_inc;
        end
        if (st_q == ST_QUOTED) begin
          if (byte_q == CH_QUOTE) begin
            st_d = ST_CLOSED;
          end else begin
            emit    = 1'b1;
            cbyte_d = byte_q;
          end
        end else if (st_q == ST_CLOSED && byte_q == CH_QUOTE) begin
          // doubled quote gives one literal quote
          st_d    = ST_QUOTED;
          emit    = 1'b1;
          cbyte_d = CH_QUOTE;
        end else if (byte_q == CH_COMMA) begin
          st_d   = ST_START;
          emit   = 1'b1;
          kind_d = KIND_FIELD;
        end else if (byte_q == CH_CR || byte_q == CH_LF) begin
          if (byte_q == CH_CR) begin
            skip_lf_d = 1'b1;
            cnt_d     = cnt_inc;
          end
          st_d       = ST_START;
          has_data_d = 1'b0;
          emit       = 1'b1;
          kind_d     = KIND_RECORD;
        end else if (byte_q == CH_QUOTE && st_q == ST_START) begin
          st_d = ST_QUOTED;
        end else if (byte_q == CH_QUOTE || st_q == ST_CLOSED) begin
          err_d  = 1'b1;
          emit   = 1'b1;
          kind_d = KIND_ERROR;
        end else begin
          st_d    = ST_PLAIN;
          emit    = 1'b1;
          cbyte_d = byte_q;
        end
      end
    end

    // Event carries the count after this byte's own line bump.
    lnum_ext = {{LINE_OUT_W{1'b0}}, cnt_d};
    lnum_d   = lnum_ext[LINE_OUT_W-1:0];

    // End of stream: back to reset values.
    if (op_q == OP_EOS) begin
      st_d       = ST_START;
      cnt_d      = LINE_ONE;
      has_data_d = 1'b0;
      skip_lf_d  = 1'b0;
      err_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      op_q   <= in_i.op;
      byte_q <= in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_START;
      cnt_q      <= LINE_ONE;
      has_data_q <= 1'b0;
      skip_lf_q  <= 1'b0;
      err_q      <= 1'b0;
    end else if (advance) begin
      st_q       <= st_d;
      cnt_q      <= cnt_d;
      has_data_q <= has_data_d;
      skip_lf_q  <= skip_lf_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= emit;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      kind_q  <= kind_d;
      cbyte_q <= cbyte_d;
      ecode_q <= ecode_d;
      lnum_q  <= lnum_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.kind         = kind_q;
  assign out_o.content_byte = cbyte_q;
  assign out_o.err_code     = ecode_q;
  assign out_o.line_number  = lnum_q;

  // Line counter starts at one and saturates, so it never reads zero.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0)
    else $error("line counter reached zero");

  // A pending LF swallow only follows a record end, which leaves the start state.
  a_skip_in_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_lf_q |-> (st_q == ST_START && !has_data_q))
    else $error("LF swallow pending outside start state");

  // A held word behind a stalled event blocks new input.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while parse stage is stalled");

endmodule

### sim/csv_field_parser_tb.sv
module csv_field_parser_tb;
  import cfp_pkg::*;

  localparam int unsigned RAND_WORDS = 624;
  localparam int unsigned DIR_ROWS   = 26;
  localparam int unsigned IDLE_PCT   = 18;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    PS_START,
    PS_PLAIN,
    PS_QUOTED,
    PS_CLOSED
  } pstate_e;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            cb;
    err_code_e             code;
    logic [LINE_OUT_W-1:0] line;
  } event_t;

  // pinned rows carry an event typed in by hand, used instead of the prediction
  typedef struct packed {
    op_e        op;
    logic [7:0] b;
    bit         pinned;
    bit         has_ev;
    event_t     ev;
  } stim_row_t;

  logic clk;
  logic rst_n;
  bit   steady;

  cfp_in_if  in_ch ();
  cfp_out_if out_ch ();

  csv_field_parser DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predictor state
  pstate_e         pst         = PS_START;
  logic [31:0]     lines       = 32'd1;
  bit              has_data    = 1'b0;
  bit              skip_lf     = 1'b0;
  bit              err_latched = 1'b0;

  event_t          pending_events [$];
  int unsigned     sent_words;
  int unsigned     errors;
  stim_row_t       dir_tab [DIR_ROWS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic event_t make_event(kind_e k, logic [7:0] cb, err_code_e e);
    event_t r;
    r.kind = k;
    r.cb   = cb;
    r.code = e;
    r.line = lines;
    return r;
  endfunction

  function automatic bit is_special(logic [7:0] b);
    return (b == CH_QUOTE) || (b == CH_COMMA) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_special(b));
    return b;
  endfunction

  // bias toward the four delimiter bytes
  function automatic logic [7:0] noisy_byte();
    logic [7:0] b;
    case ($urandom_range(9))
      0: b = CH_QUOTE;
      1: b = CH_COMMA;
      2: b = CH_CR;
      3: b = CH_LF;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic bump_line();
    if (lines != '1) lines++;
  endtask

  task automatic parse_word(input op_e op, input logic [7:0] c,
                            output bit got, output event_t r);
    got = 1'b0;
    r   = '0;
    if (op == OP_EOS) begin
      if (!err_latched) begin
        if (pst == PS_QUOTED) begin
          got = 1'b1;
          r   = make_event(KIND_ERROR, 8'h00, ERR_UNCLOSED);
        end else if (has_data) begin
          got = 1'b1;
          r   = make_event(KIND_RECORD, 8'h00, ERR_BAD_QUOTE);
        end
      end
      pst         = PS_START;
      lines       = 32'd1;
      has_data    = 1'b0;
      skip_lf     = 1'b0;
      err_latched = 1'b0;
    end else if (!err_latched) begin
      if (skip_lf && c == CH_LF) begin
        skip_lf = 1'b0;   // LF of a CRLF pair
      end else begin
        skip_lf  = 1'b0;
        has_data = 1'b1;
        if (c == CH_LF) bump_line();
        got = 1'b1;
        if (pst == PS_QUOTED) begin
          if (c == CH_QUOTE) begin
            pst = PS_CLOSED;
            got = 1'b0;
          end else begin
            r = make_event(KIND_BYTE, c, ERR_BAD_QUOTE);
          end
        end else if (pst == PS_CLOSED && c == CH_QUOTE) begin
          pst = PS_QUOTED;   // doubled quote
          r   = make_event(KIND_BYTE, CH_QUOTE, ERR_BAD_QUOTE);
        end else if (c == CH_COMMA) begin
          pst = PS_START;
          r   = make_event(KIND_FIELD, 8'h00, ERR_BAD_QUOTE);
        end else if (c == CH_CR || c == CH_LF) begin
          if (c == CH_CR) begin
            skip_lf = 1'b1;
            bump_line();
          end
          pst      = PS_START;
          has_data = 1'b0;
          r        = make_event(KIND_RECORD, 8'h00, ERR_BAD_QUOTE);
        end else if (c == CH_QUOTE && pst == PS_START) begin
          pst = PS_QUOTED;
          got = 1'b0;
        end else if (c == CH_QUOTE || pst == PS_CLOSED) begin
          err_latched = 1'b1;
          r           = make_event(KIND_ERROR, 8'h00, ERR_BAD_QUOTE);
        end else begin
          pst = PS_PLAIN;
          r   = make_event(KIND_BYTE, c, ERR_BAD_QUOTE);
        end
      end
    end
  endtask

  // present one word, wait for acceptance, record what it should cause
  task automatic send_word(input op_e op, input logic [7:0] b, input bit pinned = 1'b0,
                           input bit pin_has = 1'b0, input event_t pin_ev = '0);
    bit     got;
    event_t r;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent_words++;
    parse_word(op, b, got, r);
    if (pinned) begin
      got = pin_has;
      r   = pin_ev;
    end
    if (got) pending_events = {pending_events, r};
  endtask

  task automatic drain_events();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  task automatic send_field(input bit quoted);
    int n;
    n = $urandom_range(0, 5);
    if (quoted) begin
      send_word(OP_DATA, CH_QUOTE);
      repeat (n) begin
        case ($urandom_range(9))
          0: begin
            send_word(OP_DATA, CH_QUOTE);
            send_word(OP_DATA, CH_QUOTE);
          end
          1: send_word(OP_DATA, CH_COMMA);
          2: send_word(OP_DATA, CH_CR);
          3: send_word(OP_DATA, CH_LF);
          default: send_word(OP_DATA, plain_byte());
        endcase
      end
      send_word(OP_DATA, CH_QUOTE);
    end else begin
      repeat (n) send_word(OP_DATA, plain_byte());
    end
  endtask

  task automatic send_record();
    int nf;
    nf = $urandom_range(1, 4);
    for (int i = 0; i < nf; i++) begin
      send_field($urandom_range(9) >= 5);
      if (i < nf - 1) send_word(OP_DATA, CH_COMMA);
    end
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
        send_word(OP_DATA, CH_CR);
        send_word(OP_DATA, CH_LF);
      end
      10, 11, 12, 13, 14: send_word(OP_DATA, CH_LF);
      15, 16, 17:         send_word(OP_DATA, CH_CR);
      default:            send_word(OP_EOS, 8'($urandom_range(255)));
    endcase
  endtask

  task automatic send_broken();
    case ($urandom_range(2))
      0: begin
        repeat ($urandom_range(1, 3)) send_word(OP_DATA, plain_byte());
        send_word(OP_DATA, CH_QUOTE);
      end
      1: begin
        send_field(1'b1);
        send_word(OP_DATA, plain_byte());
      end
      default: begin
        send_word(OP_DATA, CH_QUOTE);
        repeat ($urandom_range(0, 3)) send_word(OP_DATA, noisy_byte());
        send_word(OP_EOS, 8'($urandom_range(255)));
      end
    endcase
    repeat ($urandom_range(0, 3)) send_word(OP_DATA, noisy_byte());
    if ($urandom_range(9) < 7) send_word(OP_EOS, 8'($urandom_range(255)));
  endtask

  // result side: random back-pressure and in-order checking
  always @(posedge clk) begin
    event_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected word kind=%0d byte=%02h code=%0d line=%0d", $time,
                 out_ch.kind, out_ch.content_byte, out_ch.err_code, out_ch.line_number);
        errors++;
      end else begin
        e = pending_events.pop_front();
        if (out_ch.kind !== e.kind) begin
          $display("%0t: kind exp %0d act %0d", $time, e.kind, out_ch.kind);
          errors++;
        end
        if (out_ch.content_byte !== e.cb) begin
          $display("%0t: content_byte exp %02h act %02h", $time, e.cb, out_ch.content_byte);
          errors++;
        end
        if (out_ch.err_code !== e.code) begin
          $display("%0t: err_code exp %0d act %0d", $time, e.code, out_ch.err_code);
          errors++;
        end
        if (out_ch.line_number !== e.line) begin
          $display("%0t: line_number exp %0d act %0d", $time, e.line, out_ch.line_number);
          errors++;
        end
      end
    end
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    int unsigned next_drain;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_DATA;
    in_ch.data_byte = 8'h00;
    out_ch.ready    = 1'b0;
    sent_words      = 0;
    errors          = 0;

    dir_tab = '{
      '{OP_EOS,  8'h00,    1'b1, 1'b0, '0},
      '{OP_DATA, 8'h61,    1'b1, 1'b1, '{KIND_BYTE, 8'h61, ERR_BAD_QUOTE, 32'd1}},
      '{OP_DATA, CH_COMMA, 1'b1, 1'b1, '{KIND_FIELD, 8'h00, ERR_BAD_QUOTE, 32'd1}},
      '{OP_DATA, CH_QUOTE, 1'b0, 1'b0, '0},
      '{OP_DATA, CH_QUOTE, 1'b0, 1'b0, '0},
      '{OP_DATA, CH_QUOTE, 1'b0, 1'b0, '0},
      '{OP_DATA, CH_CR,    1'b0, 1'b0, '0},
      '{OP_DATA, CH_LF,    1'b0, 1'b0, '0},
      '{OP_DATA, CH_QUOTE, 1'b0, 1'b0, '0},
      '{OP_DATA, CH_CR,    1'b1, 1'b1, '{KIND_RECORD, 8'h00, ERR_BAD_QUOTE, 32'd3}},
      '{OP_DATA, CH_LF,    1'b1, 1'b0, '0},
      '{OP_DATA, CH_LF,    1'b1, 1'b1, '{KIND_RECORD, 8'h00, ERR_BAD_QUOTE, 32'd4}},
      '{OP_DATA, 8'hFF,    1'b1, 1'b1, '{KIND_BYTE, 8'hFF, ERR_BAD_QUOTE, 32'd4}},
      '{OP_DATA, 8'h00,    1'b1, 1'b1, '{KIND_BYTE, 8'h00, ERR_BAD_QUOTE, 32'd4}},
      '{OP_DATA, CH_QUOTE, 1'b1, 1'b1, '{KIND_ERROR, 8'h00, ERR_BAD_QUOTE, 32'd4}},
      '{OP_DATA, 8'h78,    1'b1, 1'b0, '0},
      '{OP_EOS,  8'h00,    1'b1, 1'b0, '0},
      '{OP_DATA, CH_QUOTE, 1'b0, 1'b0, '0},
      '{OP_DATA, 8'h71,    1'b0, 1'b0, '0},
      '{OP_EOS,  8'h00,    1'b1, 1'b1, '{KIND_ERROR, 8'h00, ERR_UNCLOSED, 32'd1}},
      '{OP_DATA, 8'h7A,    1'b1, 1'b1, '{KIND_BYTE, 8'h7A, ERR_BAD_QUOTE, 32'd1}},
      '{OP_EOS,  8'h00,    1'b1, 1'b1, '{KIND_RECORD, 8'h00, ERR_BAD_QUOTE, 32'd1}},
      '{OP_DATA, CH_QUOTE, 1'b0, 1'b0, '0},
      '{OP_DATA, CH_QUOTE, 1'b0, 1'b0, '0},
      '{OP_DATA, 8'h6B,    1'b1, 1'b1, '{KIND_ERROR, 8'h00, ERR_BAD_QUOTE, 32'd1}},
      '{OP_EOS,  8'hFF,    1'b1, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_word(dir_tab[i].op, dir_tab[i].b, dir_tab[i].pinned, dir_tab[i].has_ev,
                dir_tab[i].ev);
    drain_events();

    next_drain = sent_words + 160;
    while (sent_words < DIR_ROWS + RAND_WORDS) begin
      steady <= (sent_words >= 300 && sent_words < 420);
      if (sent_words >= next_drain) begin
        drain_events();
        next_drain += 160;
      end
      case ($urandom_range(99)) inside
        [0:69]:  send_record();
        [70:84]: repeat ($urandom_range(1, 6)) send_word(OP_DATA, noisy_byte());
        [85:94]: send_broken();
        default: send_word(OP_EOS, 8'($urandom_range(255)));
      endcase
    end

    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
